### hdl/gta_pkg.sv
// ----------------------------------------------------------------------------
// gta_pkg - shared types and constants of the grid tile assigner
// widths, register indexes, membership codes and the structs that travel
// between the front, the queue and the back
// ----------------------------------------------------------------------------
package gta_pkg;

   // coordinate width; cell indices are one bit wider
   localparam int COORD_BITS    = 32;
   localparam int CELL_BITS     = COORD_BITS + 1;
   localparam int LEN_BITS      = 31;
   localparam int CSR_DATA_BITS = (COORD_BITS > LEN_BITS) ? COORD_BITS : LEN_BITS;
   localparam int CSR_ADDR_BITS = 3;
   localparam int DIV_CNT_BITS  = $clog2(CELL_BITS + 1);

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] REG_CELL_LENGTH = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_ORIGIN_X    = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_ORIGIN_Y    = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_ORIGIN_AUTO = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_OVERLAP     = 3'd4;

   // register reset values
   localparam logic [LEN_BITS-1:0] CELL_LENGTH_RESET = LEN_BITS'(1000);

   // membership codes
   localparam logic [1:0] MEMB_HOME = 2'd0;
   localparam logic [1:0] MEMB_X    = 2'd1;
   localparam logic [1:0] MEMB_Y    = 2'd2;
   localparam logic [1:0] MEMB_DIAG = 2'd3;

   typedef struct packed {
      logic [LEN_BITS-1:0]          cell_length;
      logic signed [COORD_BITS-1:0] anchor_x;
      logic signed [COORD_BITS-1:0] anchor_y;
      logic                         origin_auto;
      logic [LEN_BITS-1:0]          overlap;
   } cfg_type;

   // one classified point waiting for the back end
   typedef struct packed {
      logic                        fault;
      logic signed [CELL_BITS-1:0] dist_x;
      logic signed [CELL_BITS-1:0] dist_y;
   } qent_type;

endpackage

### hdl/gta_front.sv
// ----------------------------------------------------------------------------
// gta_front - point intake and classification
// checks the overlap fault, latches the automatic origin and forms the
// offsets of the point from the origin
// ----------------------------------------------------------------------------
module gta_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gta_pkg::cfg_type                      cfg,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [gta_pkg::COORD_BITS-1:0] req_point_x,
   input  logic signed [gta_pkg::COORD_BITS-1:0] req_point_y,
   output logic                                  push_valid,
   input  logic                                  push_ready,
   output gta_pkg::qent_type                     push_data
);

   logic                                  origin_known_ff, origin_known_in;
   logic signed [gta_pkg::COORD_BITS-1:0] base_x_ff, base_x_in;
   logic signed [gta_pkg::COORD_BITS-1:0] base_y_ff, base_y_in;
   logic                                  fault;
   logic                                  accept;
   logic                                  latch;
   logic signed [gta_pkg::COORD_BITS-1:0] org_x, org_y;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   // fault when twice the overlap reaches the cell length
   assign fault = {cfg.overlap, 1'b0} >= {1'b0, cfg.cell_length};
   assign latch = cfg.origin_auto && !origin_known_ff && !fault;

   always_comb begin
      if (!cfg.origin_auto) begin
         org_x = cfg.anchor_x;
         org_y = cfg.anchor_y;
      end else if (origin_known_ff) begin
         org_x = base_x_ff;
         org_y = base_y_ff;
      end else begin
         org_x = req_point_x;
         org_y = req_point_y;
      end
   end

   always_comb begin
      push_data.fault  = fault;
      push_data.dist_x = gta_pkg::CELL_BITS'(req_point_x) - gta_pkg::CELL_BITS'(org_x);
      push_data.dist_y = gta_pkg::CELL_BITS'(req_point_y) - gta_pkg::CELL_BITS'(org_y);
   end

   always_comb begin
      origin_known_in = origin_known_ff;
      base_x_in       = base_x_ff;
      base_y_in       = base_y_ff;
      if (accept && latch) begin
         origin_known_in = 1'b1;
         base_x_in       = req_point_x;
         base_y_in       = req_point_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_known_ff <= 1'b0;
         base_x_ff       <= '0;
         base_y_ff       <= '0;
      end else begin
         origin_known_ff <= origin_known_in;
         base_x_ff       <= base_x_in;
         base_y_ff       <= base_y_in;
      end
   end

endmodule

### hdl/gta_queue.sv
// ----------------------------------------------------------------------------
// gta_queue - two-entry queue between front and back
// lets intake continue while the back end divides
// ----------------------------------------------------------------------------
module gta_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  gta_pkg::qent_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output gta_pkg::qent_type pop_data
);

   gta_pkg::qent_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/gta_div.sv
// ----------------------------------------------------------------------------
// gta_div - restoring radix-2 divider
// unsigned offset magnitude by cell length, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gta_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [gta_pkg::CELL_BITS-1:0]      dividend,
   input  logic [gta_pkg::LEN_BITS-1:0]       divisor,
   output logic                               done,
   output logic [gta_pkg::CELL_BITS-1:0]      quot,
   output logic [gta_pkg::LEN_BITS-1:0]       rem
);

   logic [gta_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                             done_ff, done_in;
   logic [gta_pkg::LEN_BITS-1:0]     rem_ff, rem_in;
   logic [gta_pkg::CELL_BITS-1:0]    quo_ff, quo_in;
   logic [gta_pkg::LEN_BITS-1:0]     dsr_ff, dsr_in;
   logic [gta_pkg::LEN_BITS:0]       trial;
   logic [gta_pkg::LEN_BITS+1:0]     diff;
   logic                             ge;

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

   // shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, quo_ff[gta_pkg::CELL_BITS-1]};
   assign diff  = {1'b0, trial} - {2'b00, dsr_ff};
   assign ge    = !diff[gta_pkg::LEN_BITS+1];

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = gta_pkg::DIV_CNT_BITS'(gta_pkg::CELL_BITS);
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         rem_in  = ge ? diff[gta_pkg::LEN_BITS-1:0] : trial[gta_pkg::LEN_BITS-1:0];
         quo_in  = {quo_ff[gta_pkg::CELL_BITS-2:0], ge};
         done_in = (cnt_ff == gta_pkg::DIV_CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

endmodule

### hdl/gta_back.sv
// ----------------------------------------------------------------------------
// gta_back - cell assignment and result sequencing
// divides both offsets, finds the home cell and the overlap neighbors
// and hands results out one beat at a time
// ----------------------------------------------------------------------------
module gta_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gta_pkg::cfg_type                     cfg,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  gta_pkg::qent_type                    pop_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [gta_pkg::CELL_BITS-1:0] rsp_cell_x,
   output logic signed [gta_pkg::CELL_BITS-1:0] rsp_cell_y,
   output logic [1:0]                           rsp_membership,
   output logic                                 rsp_config_fault,
   output logic                                 rsp_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FLAG = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic                          fault_ff, fault_in;
   logic                          neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [gta_pkg::CELL_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [gta_pkg::LEN_BITS-1:0]  rel_x_ff, rel_x_in, rel_y_ff, rel_y_in;
   logic                          left_ff, left_in, down_ff, down_in;
   logic [3:0]                    pend_ff, pend_in;
   logic [3:0]                    sel;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [gta_pkg::CELL_BITS-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [1:0]                    memb_ff, memb_in;
   logic                          ofault_ff, ofault_in;
   logic                          olast_ff, olast_in;

   logic                          pop, div_start, div_done, out_free;
   logic                          div_done_x, div_done_y;
   logic [gta_pkg::CELL_BITS-1:0] mag_x, mag_y, quo_x, quo_y;
   logic [gta_pkg::LEN_BITS-1:0]  rem_x, rem_y, hi_lim;
   logic                          lo_x, hi_x, lo_y, hi_y, ovl_on;
   logic [gta_pkg::CELL_BITS-1:0] nx, ny;

   assign pop_ready = (state_ff == ST_IDLE);
   assign pop       = pop_valid && pop_ready;
   assign div_start = pop && !pop_data.fault;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign mag_x = pop_data.dist_x[gta_pkg::CELL_BITS-1] ? -pop_data.dist_x : pop_data.dist_x;
   assign mag_y = pop_data.dist_y[gta_pkg::CELL_BITS-1] ? -pop_data.dist_y : pop_data.dist_y;

   gta_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_x),
      .divisor  (cfg.cell_length),
      .done     (div_done_x),
      .quot     (quo_x),
      .rem      (rem_x)
   );

   gta_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_y),
      .divisor  (cfg.cell_length),
      .done     (div_done_y),
      .quot     (quo_y),
      .rem      (rem_y)
   );

   // both dividers run in lockstep
   assign div_done = div_done_x && div_done_y;

   // offset-in-cell tests against the overlap band
   assign hi_lim = cfg.cell_length - cfg.overlap;
   assign ovl_on = (cfg.overlap != '0);
   assign lo_x   = rel_x_ff < cfg.overlap;
   assign hi_x   = rel_x_ff > hi_lim;
   assign lo_y   = rel_y_ff < cfg.overlap;
   assign hi_y   = rel_y_ff > hi_lim;

   assign nx = left_ff ? cx_ff - 1'b1 : cx_ff + 1'b1;
   assign ny = down_ff ? cy_ff - 1'b1 : cy_ff + 1'b1;

   // lowest pending result goes first
   assign sel = pend_ff & (~pend_ff + 4'd1);

   always_comb begin
      state_in     = state_ff;
      fault_in     = fault_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      rel_x_in     = rel_x_ff;
      rel_y_in     = rel_y_ff;
      left_in      = left_ff;
      down_in      = down_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      memb_in      = memb_ff;
      ofault_in    = ofault_ff;
      olast_in     = olast_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               neg_x_in = pop_data.dist_x[gta_pkg::CELL_BITS-1];
               neg_y_in = pop_data.dist_y[gta_pkg::CELL_BITS-1];
               if (pop_data.fault) begin
                  fault_in = 1'b1;
                  pend_in  = 4'b0001;
                  state_in = ST_EMIT;
               end else begin
                  fault_in = 1'b0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               // negative offsets land one cell lower
               cx_in    = neg_x_ff ? ~quo_x : quo_x;
               cy_in    = neg_y_ff ? ~quo_y : quo_y;
               rel_x_in = neg_x_ff ? cfg.cell_length - rem_x : rem_x;
               rel_y_in = neg_y_ff ? cfg.cell_length - rem_y : rem_y;
               state_in = ST_FLAG;
            end
         end
         ST_FLAG: begin
            left_in  = lo_x;
            down_in  = lo_y;
            pend_in  = {ovl_on && (lo_x || hi_x) && (lo_y || hi_y),
                        ovl_on && (lo_y || hi_y),
                        ovl_on && (lo_x || hi_x),
                        1'b1};
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               pend_in      = pend_ff & ~sel;
               olast_in     = ((pend_ff & ~sel) == 4'b0000);
               ofault_in    = fault_ff;
               if (fault_ff) begin
                  out_x_in = '0;
                  out_y_in = '0;
                  memb_in  = gta_pkg::MEMB_HOME;
               end else begin
                  priority case (1'b1)
                     sel[0]: begin
                        out_x_in = cx_ff;
                        out_y_in = cy_ff;
                        memb_in  = gta_pkg::MEMB_HOME;
                     end
                     sel[1]: begin
                        out_x_in = nx;
                        out_y_in = cy_ff;
                        memb_in  = gta_pkg::MEMB_X;
                     end
                     sel[2]: begin
                        out_x_in = cx_ff;
                        out_y_in = ny;
                        memb_in  = gta_pkg::MEMB_Y;
                     end
                     default: begin
                        out_x_in = nx;
                        out_y_in = ny;
                        memb_in  = gta_pkg::MEMB_DIAG;
                     end
                  endcase
               end
               if ((pend_ff & ~sel) == 4'b0000) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fault_ff  <= fault_in;
      neg_x_ff  <= neg_x_in;
      neg_y_ff  <= neg_y_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      rel_x_ff  <= rel_x_in;
      rel_y_ff  <= rel_y_in;
      left_ff   <= left_in;
      down_ff   <= down_in;
      pend_ff   <= pend_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      memb_ff   <= memb_in;
      ofault_ff <= ofault_in;
      olast_ff  <= olast_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_x       = out_x_ff;
   assign rsp_cell_y       = out_y_ff;
   assign rsp_membership   = memb_ff;
   assign rsp_config_fault = ofault_ff;
   assign rsp_last         = olast_ff;

endmodule

### hdl/grid_tile_assigner_with_overlap.sv
// ----------------------------------------------------------------------------
// grid_tile_assigner_with_overlap - square grid cells of a point
// home cell plus at most one x, one y and one diagonal overlap neighbor
// ----------------------------------------------------------------------------
// a point passes the front, a queue slot, the dividers and the flag step before
//   its home-cell rsp beat; the back end takes no new point until the last of
//   its n result beats (n = 1..4) is registered; it runs two parallel 33-step
//   radix-2 dividers, which a point with an overlap fault skips for one result beat
// reset: synchronous, clears registers to their reset values, the latched
//   origin and the queue; no clearing pass
// ----------------------------------------------------------------------------
module grid_tile_assigner_with_overlap (
   input  logic                                     clock,
   input  logic                                     reset,
   // configuration writes
   input  logic                                     csr_we,
   input  logic [gta_pkg::CSR_ADDR_BITS-1:0]        csr_addr,
   input  logic [gta_pkg::CSR_DATA_BITS-1:0]        csr_wdata,
   // point beats
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [gta_pkg::COORD_BITS-1:0]    req_point_x,
   input  logic signed [gta_pkg::COORD_BITS-1:0]    req_point_y,
   // result beats
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [gta_pkg::CELL_BITS-1:0]     rsp_cell_x,
   output logic signed [gta_pkg::CELL_BITS-1:0]     rsp_cell_y,
   output logic [1:0]                               rsp_membership,
   output logic                                     rsp_config_fault,
   output logic                                     rsp_last
);

   gta_pkg::cfg_type  cfg_ff, cfg_in;
   logic              push_valid, push_ready;
   gta_pkg::qent_type push_data;
   logic              pop_valid, pop_ready;
   gta_pkg::qent_type pop_data;

   // register file: indexes outside the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            gta_pkg::REG_CELL_LENGTH: cfg_in.cell_length = csr_wdata[gta_pkg::LEN_BITS-1:0];
            gta_pkg::REG_ORIGIN_X:    cfg_in.anchor_x    = csr_wdata[gta_pkg::COORD_BITS-1:0];
            gta_pkg::REG_ORIGIN_Y:    cfg_in.anchor_y    = csr_wdata[gta_pkg::COORD_BITS-1:0];
            gta_pkg::REG_ORIGIN_AUTO: cfg_in.origin_auto = csr_wdata[0];
            gta_pkg::REG_OVERLAP:     cfg_in.overlap     = csr_wdata[gta_pkg::LEN_BITS-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_length <= gta_pkg::CELL_LENGTH_RESET;
         cfg_ff.anchor_x    <= '0;
         cfg_ff.anchor_y    <= '0;
         cfg_ff.origin_auto <= 1'b1;
         cfg_ff.overlap     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: fault check, automatic origin, offsets from the origin
   gta_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   // short queue so intake runs while the back end divides
   gta_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: divide, home cell, neighbors, result beats out of one register
   gta_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cell_x       (rsp_cell_x),
      .rsp_cell_y       (rsp_cell_y),
      .rsp_membership   (rsp_membership),
      .rsp_config_fault (rsp_config_fault),
      .rsp_last         (rsp_last)
   );

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench of the grid tile assigner with overlap
// points go in on the req channel and the home cell plus overlap neighbors
// come back on rsp; a local predictor builds the expected beats, a monitor
// checks them in order, and both sides idle and stall at random
// ----------------------------------------------------------------------------
module tb;

   // watchdog limit on stuck_cycles; reaching it ends the run
   localparam int STUCK_LIMIT   = 4000;
   localparam int RANDOM_PHASES = 10;

   typedef struct packed {
      logic signed [gta_pkg::COORD_BITS-1:0] x;
      logic signed [gta_pkg::COORD_BITS-1:0] y;
   } point_type;

   typedef struct packed {
      logic signed [gta_pkg::CELL_BITS-1:0] cell_x;
      logic signed [gta_pkg::CELL_BITS-1:0] cell_y;
      logic [1:0]                           membership;
      logic                                 config_fault;
      logic                                 last;
   } cell_beat_type;

   // dut inputs, known from time zero
   logic                                  clock       = 1'b0;
   logic                                  reset       = 1'b1;
   logic                                  csr_we      = 1'b0;
   logic [gta_pkg::CSR_ADDR_BITS-1:0]     csr_addr    = '0;
   logic [gta_pkg::CSR_DATA_BITS-1:0]     csr_wdata   = '0;
   logic                                  req_valid   = 1'b0;
   logic signed [gta_pkg::COORD_BITS-1:0] req_point_x = '0;
   logic signed [gta_pkg::COORD_BITS-1:0] req_point_y = '0;
   logic                                  rsp_ready   = 1'b0;

   // dut outputs
   logic                                  req_ready;
   logic                                  rsp_valid;
   logic signed [gta_pkg::CELL_BITS-1:0]  rsp_cell_x;
   logic signed [gta_pkg::CELL_BITS-1:0]  rsp_cell_y;
   logic [1:0]                            rsp_membership;
   logic                                  rsp_config_fault;
   logic                                  rsp_last;

   // predictor copy of the registers and of the latched origin
   gta_pkg::cfg_type                      cfg_shadow;
   bit                                    origin_latched;
   logic signed [gta_pkg::COORD_BITS-1:0] latched_x;
   logic signed [gta_pkg::COORD_BITS-1:0] latched_y;

   point_type     pending_points[$];
   cell_beat_type expected_cells[$];
   point_type     next_point;
   cell_beat_type front_cell;

   int mismatches, points_sent, beats_seen, neighbor_beats, fault_beats, settings_used;
   int send_gap, recv_stall, stuck_cycles;
   bit send_idle, recv_idle;

   always #5 clock = ~clock;

   grid_tile_assigner_with_overlap DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cell_x       (rsp_cell_x),
      .rsp_cell_y       (rsp_cell_y),
      .rsp_membership   (rsp_membership),
      .rsp_config_fault (rsp_config_fault),
      .rsp_last         (rsp_last)
   );

   // mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap(bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // point at offset (rx, ry) in the home cell, tested against the cell
   // (kx, ky) away grown by ov on every side; the bounds are strict
   function automatic bit in_buffered_cell(longint rx, longint ry, int kx, int ky,
                                           longint len, longint ov);
      longint ax, ay;
      ax = rx - kx * len;
      ay = ry - ky * len;
      return (ax > -ov) && (ax < len + ov) && (ay > -ov) && (ay < len + ov);
   endfunction

   // expected beats of one accepted point, appended to expected_cells
   function automatic void predict_cells(logic signed [gta_pkg::COORD_BITS-1:0] px,
                                         logic signed [gta_pkg::COORD_BITS-1:0] py);
      cell_beat_type beats[$];
      cell_beat_type b;
      longint        len, ov, dx, dy, hx, hy, rx, ry;
      int            kx, ky;
      logic [1:0]    memb;
      logic [3:0]    taken;
      taken = '0;
      b     = '0;
      len   = longint'(cfg_shadow.cell_length);
      ov    = longint'(cfg_shadow.overlap);
      // overlap too wide for the cell (zero length included): one fault beat,
      // the automatic origin is left alone
      if (2 * ov >= len) begin
         b.config_fault = 1'b1;
         b.last         = 1'b1;
         expected_cells.push_back(b);
         return;
      end
      if (cfg_shadow.origin_auto && !origin_latched) begin
         latched_x      = px;
         latched_y      = py;
         origin_latched = 1'b1;
      end
      dx = longint'(px) - (cfg_shadow.origin_auto ? longint'(latched_x)
                                                  : longint'(cfg_shadow.anchor_x));
      dy = longint'(py) - (cfg_shadow.origin_auto ? longint'(latched_y)
                                                  : longint'(cfg_shadow.anchor_y));
      // truncating divide, one lower when negative: an exact negative
      // multiple lands one cell down with its offset equal to the length
      hx = dx / len;
      rx = dx % len;
      if (dx < 0) begin
         hx = hx - 1;
         rx = rx + len;
      end
      hy = dy / len;
      ry = dy % len;
      if (dy < 0) begin
         hy = hy - 1;
         ry = ry + len;
      end
      b.cell_x     = gta_pkg::CELL_BITS'(hx);
      b.cell_y     = gta_pkg::CELL_BITS'(hy);
      b.membership = gta_pkg::MEMB_HOME;
      beats.push_back(b);
      if (ov > 0) begin
         // priority: x-1, x+1; y-1, y+1; then the four diagonals
         for (int i = 0; i < 8; i++) begin
            if (i < 2) begin
               memb = gta_pkg::MEMB_X;
               kx   = (i == 0) ? -1 : 1;
               ky   = 0;
            end else if (i < 4) begin
               memb = gta_pkg::MEMB_Y;
               kx   = 0;
               ky   = (i == 2) ? -1 : 1;
            end else begin
               memb = gta_pkg::MEMB_DIAG;
               kx   = (i < 6) ? -1 : 1;
               ky   = (i % 2 == 0) ? -1 : 1;
            end
            if (!taken[memb] && in_buffered_cell(rx, ry, kx, ky, len, ov)) begin
               taken[memb]  = 1'b1;
               b.cell_x     = gta_pkg::CELL_BITS'(hx + kx);
               b.cell_y     = gta_pkg::CELL_BITS'(hy + ky);
               b.membership = memb;
               beats.push_back(b);
            end
         end
      end
      beats[beats.size() - 1].last = 1'b1;
      foreach (beats[i]) expected_cells.push_back(beats[i]);
   endfunction

   function automatic void check_field(string name, logic signed [63:0] want,
                                       logic signed [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // coordinate near the cell grid of the current settings, or anywhere
   function automatic logic signed [gta_pkg::COORD_BITS-1:0] aim_coord(
         logic signed [gta_pkg::COORD_BITS-1:0] org);
      longint len, ov, v;
      len = longint'(cfg_shadow.cell_length);
      ov  = longint'(cfg_shadow.overlap);
      if (len == 0 || $urandom_range(0, 3) == 0) return $urandom;
      v = longint'(org) + (longint'($urandom_range(0, 12)) - 6) * len;
      if ($urandom_range(0, 1) == 1)
         v = v + longint'($urandom_range(0, 32'(2 * ov + 4))) - ov - 2;
      else
         v = v + longint'($urandom_range(0, 32'(len)));
      return gta_pkg::COORD_BITS'(v);
   endfunction

   // point at an offset from the register origin
   function automatic void push_rel(longint dx, longint dy);
      point_type p;
      p.x = gta_pkg::COORD_BITS'(longint'(cfg_shadow.anchor_x) + dx);
      p.y = gta_pkg::COORD_BITS'(longint'(cfg_shadow.anchor_y) + dy);
      pending_points.push_back(p);
   endfunction

   task automatic write_reg(logic [gta_pkg::CSR_ADDR_BITS-1:0] idx,
                            logic [gta_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      case (idx)
         gta_pkg::REG_CELL_LENGTH: cfg_shadow.cell_length = data[gta_pkg::LEN_BITS-1:0];
         gta_pkg::REG_ORIGIN_X:    cfg_shadow.anchor_x    = data[gta_pkg::COORD_BITS-1:0];
         gta_pkg::REG_ORIGIN_Y:    cfg_shadow.anchor_y    = data[gta_pkg::COORD_BITS-1:0];
         gta_pkg::REG_ORIGIN_AUTO: cfg_shadow.origin_auto = data[0];
         gta_pkg::REG_OVERLAP:     cfg_shadow.overlap     = data[gta_pkg::LEN_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // every register, with junk in the bits above the length, auto and overlap fields
   task automatic apply_config(logic [gta_pkg::LEN_BITS-1:0] len,
                               logic [gta_pkg::COORD_BITS-1:0] ox,
                               logic [gta_pkg::COORD_BITS-1:0] oy, logic auto_on,
                               logic [gta_pkg::LEN_BITS-1:0] ov);
      write_reg(gta_pkg::REG_CELL_LENGTH, {1'($urandom), len});
      write_reg(gta_pkg::REG_ORIGIN_X, ox);
      write_reg(gta_pkg::REG_ORIGIN_Y, oy);
      write_reg(gta_pkg::REG_ORIGIN_AUTO, {31'($urandom), auto_on});
      write_reg(gta_pkg::REG_OVERLAP, {1'($urandom), ov});
      settings_used++;
   endtask

   // hold off until every point is in and every expected beat is out
   task automatic wait_quiet();
      @(posedge clock);
      while (pending_points.size() != 0 || req_valid || expected_cells.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   // point driver: one beat at a time from pending_points, random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         // accepted beat: predict under the settings in force now
         if (req_valid && req_ready) begin
            predict_cells(req_point_x, req_point_y);
            points_sent++;
         end
         // valid holds with its payload until the beat goes through
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_points.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               next_point = pending_points.pop_front();
               req_valid   <= 1'b1;
               req_point_x <= next_point.x;
               req_point_y <= next_point.y;
               send_gap = pick_gap(send_idle);
            end
         end
      end
   end

   // result monitor: in-order compare, random stalls on rsp_ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_seen++;
            if (expected_cells.size() == 0) begin
               $error("result beat with nothing expected: cell_x %0d cell_y %0d",
                      rsp_cell_x, rsp_cell_y);
               mismatches++;
            end else begin
               front_cell = expected_cells.pop_front();
               check_field("cell_x", front_cell.cell_x, rsp_cell_x);
               check_field("cell_y", front_cell.cell_y, rsp_cell_y);
               check_field("membership", front_cell.membership, rsp_membership);
               check_field("config_fault", front_cell.config_fault, rsp_config_fault);
               check_field("last", front_cell.last, rsp_last);
               if (front_cell.config_fault)
                  fault_beats++;
               else if (front_cell.membership != gta_pkg::MEMB_HOME)
                  neighbor_beats++;
            end
         end
         // stalls start after a beat or at random while idle
         if (recv_stall == 0 && ((rsp_valid && rsp_ready) || $urandom_range(0, 15) == 0))
            recv_stall = pick_gap(recv_idle);
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // cycles without any beat or register write
   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
   end

   initial begin
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("watchdog: no beat for %0d cycles", STUCK_LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin
      logic [gta_pkg::LEN_BITS-1:0]          len_v, ov_v;
      logic [gta_pkg::COORD_BITS-1:0]        ox_v, oy_v;
      logic                                  auto_v;
      logic signed [gta_pkg::COORD_BITS-1:0] org_x, org_y;
      point_type                             p;
      int                                    n_points;

      send_idle                = 1'b1;
      recv_idle                = 1'b1;
      cfg_shadow.cell_length   = gta_pkg::CELL_LENGTH_RESET;
      cfg_shadow.anchor_x      = '0;
      cfg_shadow.anchor_y      = '0;
      cfg_shadow.origin_auto   = 1'b1;
      cfg_shadow.overlap       = '0;
      origin_latched           = 1'b0;
      latched_x                = '0;
      latched_y                = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // overlap exactly half the length is already a fault; these points
      // must not latch the automatic origin
      write_reg(gta_pkg::REG_OVERLAP, 32'd500);
      pending_points.push_back('{32'sd5, 32'sd5});
      pending_points.push_back('{-32'sd7, 32'sd3});
      wait_quiet();

      // reset settings: the first good point becomes the origin
      write_reg(gta_pkg::REG_OVERLAP, '0);
      pending_points.push_back('{32'sd100000, -32'sd50000});
      pending_points.push_back('{32'sd100999, -32'sd49001});
      pending_points.push_back('{32'sd101000, -32'sd49000});
      // exact negative multiple, then just below the origin
      pending_points.push_back('{32'sd99000, -32'sd51000});
      pending_points.push_back('{32'sd99999, -32'sd50001});
      pending_points.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000});
      pending_points.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF});
      wait_quiet();

      // register origin with overlap: corners, edges and the strict bounds
      apply_config(31'd1000, -32'sd3000, 32'sd4000, 1'b0, 31'd100);
      push_rel(50, 50);
      push_rel(950, 950);
      push_rel(50, 950);
      push_rel(950, 50);
      push_rel(500, 500);
      push_rel(-1000, -1000);
      push_rel(100, 500);
      push_rel(99, 500);
      push_rel(900, 500);
      push_rel(901, 500);
      wait_quiet();

      // widest offsets: unit cells reach both ends of the cell index range
      apply_config(31'd1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 31'd0);
      pending_points.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000});
      pending_points.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF});
      wait_quiet();
      apply_config(31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 31'h3FFF_FFFF);
      pending_points.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000});
      pending_points.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF});
      wait_quiet();

      // random phases, one register setting each; the sender waits for all
      // results at the end of every phase
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         ox_v     = $urandom;
         oy_v     = $urandom;
         auto_v   = 1'b0;
         n_points = 18;
         case (ph)
            0: begin
               len_v = 31'd1000;
               ov_v  = 31'd100;
            end
            1: begin
               len_v = $urandom_range(2, 5000);
               ov_v  = $urandom_range(0, (len_v - 1) / 2);
            end
            2: begin
               // large cells near the widest overlap, latched origin
               len_v  = $urandom_range(1000000, 32'h7FFF_FFFF);
               ov_v   = (len_v - 1) / 2 - $urandom_range(0, 3);
               auto_v = 1'b1;
            end
            3: begin
               len_v = 31'd3;
               ov_v  = 31'd1;
            end
            4: begin
               len_v = 31'h7FFF_FFFF;
               ov_v  = 31'h3FFF_FFFF;
               ox_v  = 32'h8000_0000;
               oy_v  = 32'h7FFF_FFFF;
            end
            5: begin
               // overlap fault
               len_v    = 31'd1000;
               ov_v     = $urandom_range(500, 32'h7FFF_FFFF);
               n_points = 8;
            end
            6: begin
               // zero length always faults
               len_v    = '0;
               ov_v     = '0;
               n_points = 8;
            end
            7: begin
               len_v = 31'd1;
               ov_v  = '0;
            end
            8: begin
               len_v  = $urandom_range(1, 32'h7FFF_FFFF);
               ov_v   = $urandom_range(0, len_v / 2);
               auto_v = 1'($urandom);
            end
            default: begin
               len_v  = 31'd1000;
               ov_v   = '0;
               auto_v = 1'b1;
            end
         endcase
         // some phases run flat out on both sides
         send_idle = (ph % 4 != 3) && ($urandom_range(0, 3) != 0);
         recv_idle = (ph % 4 != 3) && ($urandom_range(0, 3) != 0);
         apply_config(len_v, ox_v, oy_v, auto_v, ov_v);
         org_x = cfg_shadow.origin_auto ? latched_x : cfg_shadow.anchor_x;
         org_y = cfg_shadow.origin_auto ? latched_y : cfg_shadow.anchor_y;
         for (int i = 0; i < n_points; i++) begin
            p.x = aim_coord(org_x);
            p.y = aim_coord(org_y);
            pending_points.push_back(p);
         end
         wait_quiet();
      end

      repeat (50) @(posedge clock);
      $display("run covered %0d points and %0d result beats: %0d overlap neighbors, %0d faults",
               points_sent, beats_seen, neighbor_beats, fault_beats);
      $display("across %0d register settings from unit to full-width cells", settings_used);
      if (mismatches == 0 && expected_cells.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
